// ===== design/cpq_pkg.sv =====
package cpq_pkg;

	localparam int TILE_W  = 16;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_TAKE   = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// decoded item handed from front to back
	typedef struct packed {
		req_kind_t          kind;
		logic [TILE_W-1:0]  tile_id;
		logic               helper;
		logic               visible;
		logic               zoom;
	} op_t;

endpackage

// ===== design/cpq_req_if.sv =====
interface cpq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] tile_id;
	logic        helper_flag;
	logic        visible_flag;
	logic        zoom_active;

	modport source (output valid, req_type, tile_id, helper_flag, visible_flag, zoom_active,
		input ready);
	modport sink (input valid, req_type, tile_id, helper_flag, visible_flag, zoom_active,
		output ready);
endinterface

// ===== design/cpq_rsp_if.sv =====
interface cpq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] taken_id;
	logic [6:0]  entry_count;

	modport source (output valid, status, taken_id, entry_count, input ready);
	modport sink (input valid, status, taken_id, entry_count, output ready);
endinterface

// ===== design/cpq_front.sv =====
module cpq_front (
	input  logic         clk,
	input  logic         arst_n,
	cpq_req_if.sink      req,
	output cpq_pkg::op_t op,
	output logic         op_valid,
	input  logic         op_ready
);
	import cpq_pkg::*;

	op_t        fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	op_t        dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.kind    = req_kind_t'(req.req_type);
		dec.tile_id = req.tile_id;
		dec.helper  = req.helper_flag;
		dec.visible = req.visible_flag;
		dec.zoom    = req.zoom_active;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign op_valid  = (cnt_q != 2'd0);
	assign pop       = op_valid && op_ready;
	assign op        = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointers disagree with count");
endmodule

// ===== design/cpq_back.sv =====
module cpq_back #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ID_WIDTH    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cpq_pkg::op_t op,
	input  logic         op_valid,
	output logic         op_ready,
	cpq_rsp_if.source    rsp
);
	import cpq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_COMPACT, S_FINISH
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       rd_q;
	logic [CW-1:0]       wr_q;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic [ID_WIDTH-1:0] rid_s1;
	logic                rh_s1;
	logic                rv_s1;
	logic [ID_WIDTH-1:0] tgt_q;
	logic                all_q;
	logic                take_q;
	logic                zoom_q;
	logic                hfound_q;
	logic                vfound_q;
	logic [ID_WIDTH-1:0] hid_q;
	logic [ID_WIDTH-1:0] vid_q;
	logic [ID_WIDTH-1:0] head_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [TILE_W-1:0]   out_taken_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [ID_WIDTH-1:0] ids_mem [QUEUE_DEPTH];
	logic                hlp_mem [QUEUE_DEPTH];
	logic                vis_mem [QUEUE_DEPTH];

	logic                out_free;
	logic                accept;
	logic                done_now;
	logic                iss;
	logic                last;
	logic                keep;
	logic                we;
	logic [AW-1:0]       wa;
	logic [ID_WIDTH-1:0] wd_id;
	logic                wd_h;
	logic                wd_v;

	assign out_free = !out_valid_q || rsp.ready;
	assign op_ready = (state_q == S_IDLE) && out_free;
	assign accept   = op_valid && op_ready;
	// items whose result is loaded straight from idle
	assign done_now = accept && ((op.kind == REQ_APPEND) || (op.kind == REQ_CLEAR) ||
		((op.kind == REQ_TAKE) && (occ_q == '0)));
	assign iss      = ((state_q == S_SCAN) || (state_q == S_COMPACT)) && (rd_q < occ_q);
	assign last     = vld_s1 && (CW'(idx_s1) == occ_q - CW'(1));
	assign keep     = all_q ? (rid_s1 != tgt_q) : (idx_s1 != '0);

	always_comb begin
		we    = 1'b0;
		wa    = wr_q[AW-1:0];
		wd_id = rid_s1;
		wd_h  = rh_s1;
		wd_v  = rv_s1;
		if (accept && op.kind == REQ_APPEND && occ_q != CW'(QUEUE_DEPTH)) begin
			we    = 1'b1;
			wa    = occ_q[AW-1:0];
			wd_id = ID_WIDTH'(op.tile_id);
			wd_h  = op.helper;
			wd_v  = op.visible;
		end else if (state_q == S_COMPACT && vld_s1 && keep) begin
			we = 1'b1;
		end
	end

	// entry store: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			ids_mem[wa] <= wd_id;
			hlp_mem[wa] <= wd_h;
			vis_mem[wa] <= wd_v;
		end
		if (iss) begin
			rid_s1 <= ids_mem[rd_q[AW-1:0]];
			rh_s1  <= hlp_mem[rd_q[AW-1:0]];
			rv_s1  <= vis_mem[rd_q[AW-1:0]];
			idx_s1 <= rd_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && !done_now) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= iss;
			if (iss) begin
				rd_q <= rd_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op.kind)
							REQ_APPEND: begin
								out_valid_q <= 1'b1;
								out_taken_q <= '0;
								if (occ_q == CW'(QUEUE_DEPTH)) begin
									out_status_q <= ST_FULL;
									out_count_q  <= COUNT_W'(occ_q);
								end else begin
									occ_q        <= occ_q + CW'(1);
									out_status_q <= ST_OK;
									out_count_q  <= COUNT_W'(occ_q + CW'(1));
								end
							end
							REQ_TAKE: begin
								if (occ_q == '0) begin
									out_valid_q  <= 1'b1;
									out_status_q <= ST_EMPTY;
									out_taken_q  <= '0;
									out_count_q  <= '0;
								end else begin
									rd_q     <= '0;
									zoom_q   <= op.zoom;
									hfound_q <= 1'b0;
									vfound_q <= 1'b0;
									state_q  <= S_SCAN;
								end
							end
							REQ_DELETE: begin
								tgt_q   <= ID_WIDTH'(op.tile_id);
								all_q   <= 1'b1;
								take_q  <= 1'b0;
								rd_q    <= '0;
								wr_q    <= '0;
								state_q <= (occ_q == '0) ? S_FINISH : S_COMPACT;
							end
							REQ_CLEAR: begin
								occ_q        <= '0;
								out_valid_q  <= 1'b1;
								out_status_q <= ST_OK;
								out_taken_q  <= '0;
								out_count_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						if (zoom_q && rh_s1 && !hfound_q) begin
							hfound_q <= 1'b1;
							hid_q    <= rid_s1;
						end
						if (rv_s1 && !vfound_q) begin
							vfound_q <= 1'b1;
							vid_q    <= rid_s1;
						end
						if (idx_s1 == '0) begin
							head_q <= rid_s1;
						end
					end
					if (last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					take_q <= 1'b1;
					all_q  <= 1'b1;
					if (hfound_q) begin
						tgt_q <= hid_q;
					end else if (vfound_q) begin
						tgt_q <= vid_q;
					end else begin
						tgt_q <= head_q;
						all_q <= 1'b0;
					end
					rd_q    <= '0;
					wr_q    <= '0;
					state_q <= S_COMPACT;
				end
				S_COMPACT: begin
					if (vld_s1 && keep) begin
						wr_q <= wr_q + CW'(1);
					end
					if (last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					occ_q        <= wr_q;
					out_valid_q  <= 1'b1;
					out_status_q <= ST_OK;
					out_taken_q  <= take_q ? TILE_W'(tgt_q) : '0;
					out_count_q  <= COUNT_W'(wr_q);
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.taken_id    = out_taken_q;
	assign rsp.entry_count = out_count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(QUEUE_DEPTH)) else $error("occupancy above depth");
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DECIDE || state_q == S_COMPACT) |-> !out_valid_q)
		else $error("result pending while working");
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT && vld_s1) |-> (wr_q <= CW'(idx_s1)))
		else $error("compaction write overtook read");
	a_empty_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> (out_taken_q == '0 && out_count_q == '0))
		else $error("empty take reports data");
endmodule

// ===== design/class_priority_request_queue_top.sv =====
// Append, clear and take-on-empty: result registered as the back end accepts the item.
// Take sweeps the entry store (one write port, one registered read port) once to
// pick the class and once to compact; delete sweeps it once to compact.
// A two-item front queue accepts new items while the back end works.
// arst_n clears occupancy, pointers and valid flags; entry store is not reset.
module class_priority_request_queue_top #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ID_WIDTH    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cpq_req_if.sink   req,
	cpq_rsp_if.source rsp
);
	import cpq_pkg::*;

	op_t  op;
	logic op_valid;
	logic op_ready;

	// front: take items, decode, buffer
	cpq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op       (op),
		.op_valid (op_valid),
		.op_ready (op_ready)
	);

	// back: entry store, class search, compaction, result register
	cpq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.rsp      (rsp)
	);
endmodule

// ===== sim/tb_class_priority_request_queue_top.sv =====
`timescale 1ns / 100ps

module tb_class_priority_request_queue_top;
	import cpq_pkg::*;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		req_kind_t         kind;
		logic [15:0]       tile_id;
		logic              helper;
		logic              visible;
		logic              zoom;
	} req_item_t;

	typedef struct {
		status_t           status;
		logic [15:0]       taken_id;
		logic [6:0]        entry_count;
	} rsp_item_t;

	// Queue predictor plus the FIFO of expected results.
	class cpq_scoreboard;
		logic [15:0] ids[$];
		logic        helpers[$];
		logic        visibles[$];
		rsp_item_t   pending[$];
		int          errors;

		function void purge_id(logic [15:0] id);
			for (int i = ids.size() - 1; i >= 0; i--) begin
				if (ids[i] == id) begin
					ids.delete(i);
					helpers.delete(i);
					visibles.delete(i);
				end
			end
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t e;
			int pos;
			e.status = ST_OK;
			e.taken_id = '0;
			pos = -1;
			case (r.kind)
				REQ_APPEND: begin
					if (ids.size() >= DEPTH) e.status = ST_FULL;
					else begin
						ids.push_back(r.tile_id);
						helpers.push_back(r.helper);
						visibles.push_back(r.visible);
					end
				end
				REQ_TAKE: begin
					if (ids.size() == 0) e.status = ST_EMPTY;
					else begin
						// helper class only while zooming, then visible, then head
						if (r.zoom)
							foreach (helpers[i]) if (pos < 0 && helpers[i]) pos = i;
						if (pos < 0)
							foreach (visibles[i]) if (pos < 0 && visibles[i]) pos = i;
						if (pos >= 0) begin
							e.taken_id = ids[pos];
							purge_id(ids[pos]);
						end else begin
							e.taken_id = ids[0];
							void'(ids.pop_front());
							void'(helpers.pop_front());
							void'(visibles.pop_front());
						end
					end
				end
				REQ_DELETE: purge_id(r.tile_id);
				default: begin
					ids.delete();
					helpers.delete();
					visibles.delete();
				end
			endcase
			e.entry_count = 7'(ids.size());
			pending.push_back(e);
		endfunction

		function void check_result(rsp_item_t a);
			rsp_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d id=%h count=%0d",
					$time, a.status, a.taken_id, a.entry_count);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, a.status);
				errors++;
			end
			if (a.taken_id !== e.taken_id) begin
				$display("%0t: taken_id exp %h got %h", $time, e.taken_id, a.taken_id);
				errors++;
			end
			if (a.entry_count !== e.entry_count) begin
				$display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
					a.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cpq_req_if req ();
	cpq_rsp_if rsp ();

	class_priority_request_queue_top #(
		.QUEUE_DEPTH(DEPTH),
		.ID_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	cpq_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int idle_cycles;
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender: one item per call, random gap before it per send_idle_pct.
	// valid stays up after an accept; a gap in the next call or the drain drops it.
	task automatic send_request(req_item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.req_type     <= r.kind;
		req.tile_id      <= r.tile_id;
		req.helper_flag  <= r.helper;
		req.visible_flag <= r.visible;
		req.zoom_active  <= r.zoom;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_fields(req_kind_t k, logic [15:0] id, logic h, logic v, logic z);
		req_item_t r;
		r.kind = k;
		r.tile_id = id;
		r.helper = h;
		r.visible = v;
		r.zoom = z;
		send_request(r);
	endtask

	// Small id pool so duplicates, delete hits and class matches are common.
	function automatic logic [15:0] pick_id();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(11));
		endcase
	endfunction

	task automatic send_random(int fill_bias);
		int p;
		p = $urandom_range(99);
		if (p < fill_bias)
			send_fields(REQ_APPEND, pick_id(), 1'($urandom), 1'($urandom), 1'($urandom));
		else if (p < 90)
			send_fields(REQ_TAKE, pick_id(), 1'($urandom), 1'($urandom), 1'($urandom));
		else if (p < 98)
			send_fields(REQ_DELETE, pick_id(), 1'($urandom), 1'($urandom),
				1'($urandom));
		else
			send_fields(REQ_CLEAR, pick_id(), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Receiver: random ready, sampled at the edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
			if (rsp.valid && rsp.ready) begin
				rsp_item_t a;
				a.status = status_t'(rsp.status);
				a.taken_id = rsp.taken_id;
				a.entry_count = rsp.entry_count;
				sb.check_result(a);
			end
		end
	end

	// Watchdog: cycles without any handshake.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Regression FAIL");
			$finish;
		end
	end

	// Long receiver hold-off; the sender keeps pushing so the front stalls.
	task automatic hold_receiver(int cycles);
		recv_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		recv_hold = 1'b0;
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1'b0;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_APPEND;
		req.tile_id = '0;
		req.helper_flag = 1'b0;
		req.visible_flag = 1'b0;
		req.zoom_active = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: take on empty, id extremes, class priority, delete, clear.
		send_fields(REQ_TAKE, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_APPEND, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_APPEND, 16'hFFFF, 1'b0, 1'b1, 1'b0);
		send_fields(REQ_APPEND, 16'h5A5A, 1'b1, 1'b0, 1'b0);
		send_fields(REQ_APPEND, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		send_fields(REQ_APPEND, 16'hA5A5, 1'b0, 1'b0, 1'b0);
		// zoom: oldest helper wins
		send_fields(REQ_TAKE, 16'h1234, 1'b0, 1'b0, 1'b1);
		// no zoom: oldest visible wins, all copies removed
		send_fields(REQ_TAKE, 16'h0000, 1'b1, 1'b1, 1'b0);
		// delete with absent id, then present id
		send_fields(REQ_DELETE, 16'h7777, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_DELETE, 16'h0000, 1'b0, 1'b0, 1'b0);
		// no flagged entries left: head pop
		send_fields(REQ_TAKE, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_APPEND, 16'h0001, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_CLEAR, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_TAKE, 16'h0000, 1'b0, 1'b0, 1'b0);
		// fill to the top and overflow
		for (int i = 0; i < DEPTH + 2; i++)
			send_fields(REQ_APPEND, 16'(i * 1021), 1'(i % 7 == 3), 1'(i % 5 == 4),
				1'b0);
		send_fields(REQ_CLEAR, 16'h0000, 1'b0, 1'b0, 1'b0);

		// Receiver holds off while items keep arriving.
		fork
			hold_receiver(400);
			repeat (12) send_fields(REQ_APPEND, pick_id(), 1'($urandom), 1'($urandom),
				1'b0);
		join

		// Random phases: idling profile changes, fill bias sweeps the occupancy.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 55 : 0;
			recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 15 : 0;
			for (int n = 0; n < 290; n++)
				send_random((n % 100 < 50) ? 75 : 35);
		end

		// Drain.
		req.valid <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 20) @(posedge clk);
		if (sb.errors == 0 && !timed_out)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/cpq_pkg.sv
design/cpq_req_if.sv
design/cpq_rsp_if.sv
design/cpq_front.sv
design/cpq_back.sv
design/class_priority_request_queue_top.sv
sim/tb_class_priority_request_queue_top.sv
